[hdl/opst_pkg.sv]
// Shared types and constants of the shortest-path open-set table.
// Holds command and status codes, sequencer states and the compare flag bundle.
// No dependencies.
package opst_pkg;

	// fixed field widths of the ports
	localparam int NODE_PORT_W = 16;
	localparam int DIST_W      = 32;

	// distance value meaning "unreachable"
	localparam logic [DIST_W-1:0] INF_DIST = '1;

	// command codes
	localparam logic [2:0] CMD_INSERT = 3'd0;
	localparam logic [2:0] CMD_UPDATE = 3'd1;
	localparam logic [2:0] CMD_REMOVE = 3'd2;
	localparam logic [2:0] CMD_QUERY  = 3'd3;
	localparam logic [2:0] CMD_MIN    = 3'd4;

	// status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_NOTFOUND = 2'd1;
	localparam logic [1:0] STAT_FULL     = 2'd2;
	localparam logic [1:0] STAT_EMPTY    = 2'd3;

	// sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	// result of the shared compare unit
	typedef struct packed {
		logic node_eq;
		logic dist_lt;
		logic pred_eq;
	} cmp_flags_t;

endpackage

[hdl/opst_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module opst_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/opst_cmp.sv]
// Shared compare unit: checks one table entry against the search key.
// Depends on opst_pkg.
module opst_cmp #(
	parameter int NW = 16
) (
	input  logic [NW-1:0]                  entry_node,
	input  logic [opst_pkg::DIST_W-1:0]    entry_dist,
	input  logic [NW-1:0]                  entry_pred,
	input  logic [NW-1:0]                  key_node,
	input  logic [opst_pkg::DIST_W-1:0]    best_dist,
	input  logic [NW-1:0]                  key_src,
	output opst_pkg::cmp_flags_t           flags
);

	// node match, strict distance improvement, predecessor match
	always_comb begin
		flags.node_eq = (entry_node == key_node);
		flags.dist_lt = (entry_dist < best_dist);
		flags.pred_eq = (entry_pred == key_src);
	end

endmodule

[hdl/shortest_path_open_set_table_unit.sv]
// Top level of the shortest-path open-set table: sequencer, table RAM, output register.
// Depends on opst_pkg, opst_ram and opst_cmp.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one command transaction: cmd, node,
//   pred_in, dist_in, edge_source. Output channel (out_valid/out_ready) returns
//   exactly one result transaction per command: status, dist_out, pred_out,
//   edge_match, min_node. Commands are served one at a time, in order.
//   The table lives in one RAM with one read and one write port. Each command
//   scans the stored entries, one RAM read per cycle, through one shared compare
//   unit. Insert, update and query stop at the first matching entry; remove
//   keeps scanning and moves each later entry down by one as it is read;
//   minimum reads every entry. Unused command codes read no entries. in_ready
//   is high only while the sequencer is idle, so a new command is taken only
//   after the result of the last one has been loaded into the output register.
//   Reset empties the table (entry count zero); RAM contents are not cleared.
//   A finished result waits in the output register while out_ready is low; the
//   sequencer holds its result until that register frees, and meanwhile takes
//   no new command.
module shortest_path_open_set_table_unit #(
	parameter int MAX_ENTRIES = 64,
	parameter int NODE_BITS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  cmd,
	input  logic [15:0] node,
	input  logic [15:0] pred_in,
	input  logic [31:0] dist_in,
	input  logic [15:0] edge_source,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [31:0] dist_out,
	output logic [15:0] pred_out,
	output logic        edge_match,
	output logic [15:0] min_node
);

	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int NW = (NODE_BITS < 16) ? NODE_BITS : 16;
	localparam int DW = opst_pkg::DIST_W;
	localparam int PW = opst_pkg::NODE_PORT_W;
	localparam int MW = 2 * NW + DW;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);
	localparam logic [PW-1:0] NO_ID16 = PW'((32'd1 << NW) - 32'd1);

	opst_pkg::state_t state_q, state_d;

	// latched command
	logic [2:0]    cmd_q;
	logic [NW-1:0] node_q, pred_q, src_q;
	logic [DW-1:0] dist_q;

	// table and scan control
	logic [CW-1:0] count_q;
	logic [CW-1:0] rd_ptr_q;
	logic          chk_v_q;
	logic [AW-1:0] chk_idx_q;
	logic          found_q;
	logic [AW-1:0] hit_idx_q;
	logic [DW-1:0] hit_dist_q;
	logic [NW-1:0] hit_pred_q;
	logic          match_q;
	logic [DW-1:0] best_dist_q;
	logic [NW-1:0] best_node_q;

	// output register
	logic          out_valid_q;
	logic [1:0]    status_q;
	logic [DW-1:0] dist_out_q;
	logic [PW-1:0] pred_out_q, min_node_q;
	logic          match_out_q;

	// memory port signals
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [MW-1:0] mem_wdata, rdata;
	logic [NW-1:0] rd_node, rd_pred;
	logic [DW-1:0] rd_dist;

	logic take, issue, scan_done, res_load, stop_find, shift_we, full;
	logic app_we, upd_we, cnt_dec;
	logic [1:0]    res_status;
	logic [DW-1:0] res_dist;
	logic [PW-1:0] res_pred, res_min;
	logic          res_match;
	opst_pkg::cmp_flags_t flags;

	// handshake and scan control
	assign in_ready  = (state_q == opst_pkg::S_IDLE);
	assign take      = in_valid && in_ready;
	assign stop_find = found_q && (cmd_q != opst_pkg::CMD_REMOVE);
	assign issue     = (state_q == opst_pkg::S_SCAN) && (rd_ptr_q < count_q) &&
		(cmd_q <= opst_pkg::CMD_MIN) && !stop_find;
	assign scan_done = (state_q == opst_pkg::S_SCAN) && !issue && !chk_v_q;
	assign res_load  = (state_q == opst_pkg::S_FINISH) && (!out_valid_q || out_ready);
	assign full      = (count_q == MAX_CNT);

	// entry fields of the read word
	assign rd_node = rdata[MW-1 -: NW];
	assign rd_dist = rdata[NW +: DW];
	assign rd_pred = rdata[NW-1:0];

	opst_ram #(
		.WIDTH(MW),
		.DEPTH(MAX_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (issue),
		.raddr (rd_ptr_q[AW-1:0]),
		.rdata (rdata)
	);

	opst_cmp #(
		.NW(NW)
	) u_cmp (
		.entry_node (rd_node),
		.entry_dist (rd_dist),
		.entry_pred (rd_pred),
		.key_node   (node_q),
		.best_dist  (best_dist_q),
		.key_src    (src_q),
		.flags      (flags)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= opst_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			opst_pkg::S_IDLE: begin
				if (take) state_d = opst_pkg::S_SCAN;
			end
			opst_pkg::S_SCAN: begin
				if (scan_done) state_d = opst_pkg::S_FINISH;
			end
			opst_pkg::S_FINISH: begin
				if (res_load) state_d = opst_pkg::S_IDLE;
			end
			default: state_d = opst_pkg::S_IDLE;
		endcase
	end

	// result and final table update once the scan is over
	always_comb begin
		res_status = opst_pkg::STAT_OK;
		res_dist   = '0;
		res_pred   = '0;
		res_match  = 1'b0;
		res_min    = '0;
		app_we     = 1'b0;
		upd_we     = 1'b0;
		cnt_dec    = 1'b0;
		case (cmd_q) inside
			opst_pkg::CMD_INSERT, opst_pkg::CMD_UPDATE: begin
				if (found_q) begin
					upd_we = (cmd_q == opst_pkg::CMD_UPDATE);
				end else if (full) begin
					res_status = opst_pkg::STAT_FULL;
				end else begin
					app_we = 1'b1;
				end
			end
			opst_pkg::CMD_REMOVE: begin
				if (found_q) cnt_dec = 1'b1;
				else res_status = opst_pkg::STAT_NOTFOUND;
			end
			opst_pkg::CMD_QUERY: begin
				if (found_q) begin
					res_dist           = hit_dist_q;
					res_pred[NW-1:0]   = hit_pred_q;
					res_match          = match_q;
				end else begin
					res_status = opst_pkg::STAT_NOTFOUND;
					res_dist   = opst_pkg::INF_DIST;
					res_pred   = NO_ID16;
				end
			end
			opst_pkg::CMD_MIN: begin
				if (count_q == '0) begin
					res_status = opst_pkg::STAT_EMPTY;
					res_min    = NO_ID16;
				end else begin
					res_min[NW-1:0] = best_node_q;
				end
			end
			default: begin
			end
		endcase
	end

	// write port: shift during remove, else append or update at the end
	assign shift_we  = (state_q == opst_pkg::S_SCAN) && chk_v_q &&
		(cmd_q == opst_pkg::CMD_REMOVE) && found_q;
	assign mem_we    = shift_we || (res_load && (app_we || upd_we));
	assign mem_waddr = shift_we ? (chk_idx_q - AW'(1)) :
		(upd_we ? hit_idx_q : count_q[AW-1:0]);
	assign mem_wdata = shift_we ? rdata : {node_q, dist_q, pred_q};

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			chk_v_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			chk_v_q <= issue;
			if (res_load && app_we) begin
				count_q <= count_q + CW'(1);
			end else if (res_load && cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// command latch, scan pointer and check stage
	always_ff @(posedge clk) begin
		if (take) begin
			cmd_q    <= cmd;
			node_q   <= node[NW-1:0];
			pred_q   <= pred_in[NW-1:0];
			dist_q   <= dist_in;
			src_q    <= edge_source[NW-1:0];
			rd_ptr_q <= '0;
			found_q  <= 1'b0;
		end else begin
			if (issue) begin
				rd_ptr_q <= rd_ptr_q + CW'(1);
			end
			if ((state_q == opst_pkg::S_SCAN) && chk_v_q) begin
				if (cmd_q == opst_pkg::CMD_MIN) begin
					if ((chk_idx_q == '0) || flags.dist_lt) begin
						best_dist_q <= rd_dist;
						best_node_q <= rd_node;
					end
				end else if (!found_q && flags.node_eq) begin
					found_q    <= 1'b1;
					hit_idx_q  <= chk_idx_q;
					hit_dist_q <= rd_dist;
					hit_pred_q <= rd_pred;
					match_q    <= flags.pred_eq;
				end
			end
		end
		chk_idx_q <= rd_ptr_q[AW-1:0];
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (res_load) begin
			status_q    <= res_status;
			dist_out_q  <= res_dist;
			pred_out_q  <= res_pred;
			match_out_q <= res_match;
			min_node_q  <= res_min;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign dist_out   = dist_out_q;
	assign pred_out   = pred_out_q;
	assign edge_match = match_out_q;
	assign min_node   = min_node_q;

	// entry count stays within the table
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_CNT)
		else $error("entry count beyond table size");

	// entry count moves only when a result is loaded
	a_count_moves: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> $past(res_load))
		else $error("entry count changed outside result load");

	// writes during a scan happen only while closing the gap of a remove
	a_scan_write: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && (state_q == opst_pkg::S_SCAN)) |->
		((cmd_q == opst_pkg::CMD_REMOVE) && found_q))
		else $error("table write during scan outside remove");

	// empty-table status carries the no-node code
	a_empty_min: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q == opst_pkg::STAT_EMPTY)) |-> (min_node_q == NO_ID16))
		else $error("empty status without no-node code");

endmodule
